// ----- src/keyframe_scale_lerp_unit_defines.svh -----
// Assertion macros for the keyframe scale interpolation unit.
// Used by keyframe_scale_lerp_unit.sv; expects clk and rst in scope.
`ifndef KEYFRAME_SCALE_LERP_UNIT_DEFINES_SVH
`define KEYFRAME_SCALE_LERP_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KSL_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("keyframe lerp unit: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define KSL_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("keyframe lerp unit: next-cycle check failed");

`endif

// ----- src/ksl_pkg.sv -----
// Shared types and constants for the keyframe scale interpolation unit.
// No dependencies; imported by the top level, the checker and the testbench.
package ksl_pkg;

  localparam int FRAME_W   = 24;
  localparam int VAL_W     = 24;
  localparam int FRAC_BITS = 8;
  localparam int COUNT_W   = 7;
  localparam int SLOT_W    = 6;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_BEFORE   = 2'd1;
  localparam logic [1:0] STATUS_PAST_END = 2'd2;
  localparam logic [1:0] STATUS_LOADED   = 2'd3;

  typedef struct packed {
    logic                       mode;
    logic [SLOT_W-1:0]          key_slot;
    logic [FRAME_W-1:0]         key_frame;
    logic signed [VAL_W-1:0]    key_x;
    logic signed [VAL_W-1:0]    key_y;
    logic signed [VAL_W-1:0]    key_z;
    logic [FRAME_W-1:0]         query_frame;
  } item_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic signed [VAL_W-1:0]    out_x;
    logic signed [VAL_W-1:0]    out_y;
    logic signed [VAL_W-1:0]    out_z;
    logic [FRAME_W-1:0]         segment_start;
  } result_t;

  // One table row as stored in the key memory.
  typedef struct packed {
    logic [FRAME_W-1:0]         frame;
    logic signed [VAL_W-1:0]    x;
    logic signed [VAL_W-1:0]    y;
    logic signed [VAL_W-1:0]    z;
  } key_t;

endpackage

// ----- src/keyframe_scale_lerp_unit.sv -----
// Keyframe scale interpolation unit: top level with search/divide/lerp sequencer.
// Depends on ksl_pkg, ksl_ram and keyframe_scale_lerp_unit_defines.svh.
// Usage:
//   cfg channel: writes key_count, the number of valid keys (capped at MAX_KEYS).
//   item channel: a load beat (mode 0) writes one key row; a query beat (mode 1)
//   scans adjacent key pairs for start <= frame < end and interpolates x, y, z.
//   result channel: one beat per item, held in an output register.
// Sequence, accept to result_valid:
//   a load beat or an empty table goes straight to the output stage; a query
//   before the first key or with a single key ends after the key 0 check.
//   Other queries check key 0, scan one key pair per step (one key row read
//   per cycle from the single memory read port), run the restoring divider
//   that forms alpha, use the shared multiplier for each of three axes, then
//   stage the result; a past-end query skips the divide and multiply.
// Throughput: one item at a time; item_ready is high only while the sequencer
// is idle, so the next item is taken in the cycle after the previous result
// enters the output register, even while it still waits on result_ready.
// Reset clears key_count, the sequencer and result_valid; the key table is
// not cleared and must be loaded before it is queried. A stalled receiver
// holds the result beat; a finished item waits in staging until it drains.
`include "keyframe_scale_lerp_unit_defines.svh"

module keyframe_scale_lerp_unit #(
  parameter int MAX_KEYS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ksl_pkg::COUNT_W-1:0] cfg_data,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  ksl_pkg::item_t              item,
  output logic                        result_valid,
  input  logic                        result_ready,
  output ksl_pkg::result_t            result
);

  import ksl_pkg::*;

  localparam int AW     = $clog2(MAX_KEYS);
  localparam int NW     = $clog2(MAX_KEYS + 1);
  localparam int STEP_W = $clog2(FRAC_BITS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK0,
    ST_SCAN,
    ST_DIV,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  state_t                   state;
  logic [COUNT_W-1:0]       key_count;
  logic [FRAME_W-1:0]       qf;
  key_t                     prev;
  key_t                     key_b;
  logic [AW-1:0]            idx;
  logic [FRAME_W-1:0]       rem;
  logic [FRAME_W-1:0]       dvs;
  logic [FRAC_BITS-1:0]     alpha;
  logic [STEP_W-1:0]        step;
  logic [1:0]               axis;
  logic signed [33:0]       prod;
  logic [1:0]               res_status;
  logic signed [VAL_W-1:0]  res_v [3];
  logic [FRAME_W-1:0]       res_seg;

  logic [NW-1:0]            n;
  logic                     item_fire;
  logic                     ram_we;
  logic [AW-1:0]            rd_addr;
  logic [$bits(key_t)-1:0]  rd_word;
  key_t                     rd_key;
  key_t                     wr_key;
  logic                     last_pair;
  logic [FRAME_W+1:0]       div_sub;
  logic signed [VAL_W-1:0]  axis_a;
  logic signed [VAL_W-1:0]  axis_b;
  logic signed [VAL_W:0]    axis_diff;
  logic signed [VAL_W+1:0]  axis_sum;

  assign cfg_ready  = 1'b1;
  assign item_ready = (state == ST_IDLE);
  assign item_fire  = item_valid && item_ready;

  always_comb begin
    if (32'(key_count) > 32'(MAX_KEYS)) begin
      n = NW'(MAX_KEYS);
    end else begin
      n = NW'(key_count);
    end
  end

  // Key memory: one row per key, written by load beats.
  assign ram_we = item_fire && (item.mode == MODE_LOAD) && (32'(item.key_slot) < 32'(MAX_KEYS));
  assign wr_key = '{frame: item.key_frame, x: item.key_x, y: item.key_y, z: item.key_z};

  // Fetch the row needed in the next cycle.
  always_comb begin
    unique case (state)
      ST_IDLE:   rd_addr = '0;
      ST_CHECK0: rd_addr = AW'(1);
      default:   rd_addr = idx + AW'(1);
    endcase
  end

  ksl_ram #(
    .WIDTH ($bits(key_t)),
    .DEPTH (MAX_KEYS)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (AW'(item.key_slot)),
    .wr_data (wr_key),
    .rd_addr (rd_addr),
    .rd_data (rd_word)
  );

  assign rd_key    = key_t'(rd_word);
  assign last_pair = ((NW'(idx) + NW'(1)) == n);

  // Restoring divider step: shift remainder, try subtracting the span.
  assign div_sub = {1'b0, rem, 1'b0} - {2'b00, dvs};

  always_comb begin
    case (axis)
      2'd0: begin
        axis_a = prev.x;
        axis_b = key_b.x;
      end
      2'd1: begin
        axis_a = prev.y;
        axis_b = key_b.y;
      end
      default: begin
        axis_a = prev.z;
        axis_b = key_b.z;
      end
    endcase
  end

  assign axis_diff = {axis_b[VAL_W-1], axis_b} - {axis_a[VAL_W-1], axis_a};
  assign axis_sum  = {{2{axis_a[VAL_W-1]}}, axis_a} + $signed(prod[33:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      key_count    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        key_count <= cfg_data;
      end
      if (result_valid && result_ready && (state != ST_OUT)) begin
        result_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (item_valid) begin
            qf       <= item.query_frame;
            res_seg  <= item.query_frame;
            res_v[0] <= '0;
            res_v[1] <= '0;
            res_v[2] <= '0;
            if (item.mode == MODE_LOAD) begin
              res_status <= STATUS_LOADED;
              state      <= ST_OUT;
            end else if (n == '0) begin
              res_status <= STATUS_PAST_END;
              state      <= ST_OUT;
            end else begin
              state <= ST_CHECK0;
            end
          end
        end
        ST_CHECK0: begin
          prev <= rd_key;
          if (rd_key.frame > qf) begin
            res_status <= STATUS_BEFORE;
            state      <= ST_OUT;
          end else if (n == NW'(1)) begin
            res_status <= STATUS_PAST_END;
            state      <= ST_OUT;
          end else begin
            idx   <= AW'(1);
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if ((prev.frame <= qf) && (rd_key.frame > qf)) begin
            key_b <= rd_key;
            rem   <= qf - prev.frame;
            dvs   <= rd_key.frame - prev.frame;
            alpha <= '0;
            step  <= '0;
            state <= ST_DIV;
          end else begin
            prev <= rd_key;
            if (last_pair) begin
              res_status <= STATUS_PAST_END;
              state      <= ST_OUT;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        ST_DIV: begin
          if (!div_sub[FRAME_W+1]) begin
            rem <= div_sub[FRAME_W-1:0];
          end else begin
            rem <= {rem[FRAME_W-2:0], 1'b0};
          end
          alpha <= {alpha[FRAC_BITS-2:0], ~div_sub[FRAME_W+1]};
          step  <= step + STEP_W'(1);
          if (step == STEP_W'(FRAC_BITS - 1)) begin
            axis  <= 2'd0;
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod  <= axis_diff * $signed({1'b0, alpha});
          state <= ST_ACC;
        end
        ST_ACC: begin
          res_v[axis] <= axis_sum[VAL_W-1:0];
          if (axis == 2'd2) begin
            res_status <= STATUS_OK;
            res_seg    <= prev.frame;
            state      <= ST_OUT;
          end else begin
            axis  <= axis + 2'd1;
            state <= ST_MUL;
          end
        end
        ST_OUT: begin
          // Hold the staged result until the output register drains.
          if (!result_valid || result_ready) begin
            result.status        <= res_status;
            result.out_x         <= res_v[0];
            result.out_y         <= res_v[1];
            result.out_z         <= res_v[2];
            result.segment_start <= res_seg;
            result_valid         <= 1'b1;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `KSL_ASSERT_NOW(a_zero_unless_ok, result_valid && (result.status != STATUS_OK), (result.out_x == '0) && (result.out_y == '0) && (result.out_z == '0))
  `KSL_ASSERT_NEXT(a_one_item_at_a_time, item_valid && item_ready, !item_ready)
  `KSL_ASSERT_NOW(a_div_rem_below_span, state == ST_DIV, rem < dvs)

endmodule

// ----- src/ksl_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ksl_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- verif/keyframe_scale_lerp_unit_checker.sv -----
// Scoreboard for the keyframe scale interpolation unit: tracks key_count and the key
// table from observed beats, predicts each result and compares it field by field.
// Depends on ksl_pkg.
module keyframe_scale_lerp_unit_checker #(
  parameter int MAX_KEYS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [ksl_pkg::COUNT_W-1:0] cfg_data,
  input  logic                        item_valid,
  input  logic                        item_ready,
  input  ksl_pkg::item_t              item,
  input  logic                        result_valid,
  input  logic                        result_ready,
  input  ksl_pkg::result_t            result,
  output int                          errors,
  output int                          outstanding
);
  import ksl_pkg::*;

  key_t               key_rows [MAX_KEYS];
  logic [COUNT_W-1:0] key_count = '0;
  result_t            expected_q [$];
  int                 mismatch_count = 0;

  function automatic logic [VAL_W-1:0] blend_axis(input logic signed [VAL_W-1:0] a,
                                                  input logic signed [VAL_W-1:0] b,
                                                  input longint alpha);
    longint av, bv, prod, blended;
    av = a;
    bv = b;
    prod = (bv - av) * alpha;
    // arithmetic shift floors negative products
    blended = av + (prod >>> FRAC_BITS);
    return blended[VAL_W-1:0];
  endfunction

  // Apply one item to the shadow table and return the result it should produce.
  function automatic result_t interpolate_scale(input item_t it);
    result_t res;
    int      n;
    longint  qf, s, e, alpha;
    res = '0;
    res.segment_start = it.query_frame;
    if (it.mode == MODE_LOAD) begin
      if (it.key_slot < MAX_KEYS)
        key_rows[it.key_slot] = '{frame: it.key_frame, x: it.key_x, y: it.key_y, z: it.key_z};
      res.status = STATUS_LOADED;
      return res;
    end
    n  = (key_count > MAX_KEYS) ? MAX_KEYS : key_count;
    qf = it.query_frame;
    res.status = STATUS_PAST_END;
    if (n == 0)
      return res;
    if (key_rows[0].frame > it.query_frame) begin
      res.status = STATUS_BEFORE;
      return res;
    end
    for (int i = 0; i + 1 < n; i++) begin
      s = key_rows[i].frame;
      e = key_rows[i + 1].frame;
      if (s <= qf && e > qf) begin
        alpha = ((qf - s) << FRAC_BITS) / (e - s);
        res.status        = STATUS_OK;
        res.out_x         = blend_axis(key_rows[i].x, key_rows[i + 1].x, alpha);
        res.out_y         = blend_axis(key_rows[i].y, key_rows[i + 1].y, alpha);
        res.out_z         = blend_axis(key_rows[i].z, key_rows[i + 1].z, alpha);
        res.segment_start = key_rows[i].frame;
        return res;
      end
    end
    return res;
  endfunction

  task automatic compare_field(input string field, input logic [FRAME_W-1:0] want,
                               input logic [FRAME_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", field, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      key_count = '0;
      expected_q.delete();
    end else begin
      if (cfg_valid && cfg_ready)
        key_count = cfg_data;
      if (item_valid && item_ready)
        expected_q.push_back(interpolate_scale(item));
      if (result_valid && result_ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with no prediction pending: %h", result);
          mismatch_count++;
        end else begin
          want = expected_q.pop_front();
          compare_field("status", want.status, result.status);
          compare_field("out_x", want.out_x, result.out_x);
          compare_field("out_y", want.out_y, result.out_y);
          compare_field("out_z", want.out_z, result.out_z);
          compare_field("segment_start", want.segment_start, result.segment_start);
        end
      end
    end
    errors      <= mismatch_count;
    outstanding <= expected_q.size();
  end

endmodule

// ----- verif/keyframe_scale_lerp_unit_test.sv -----
// Testbench top for keyframe_scale_lerp_unit: clock, reset, key/query stimulus,
// random handshake idling and the verdict. Depends on ksl_pkg, the unit and
// keyframe_scale_lerp_unit_checker.
module keyframe_scale_lerp_unit_test;
  import ksl_pkg::*;

  localparam int KEY_SLOTS           = 64;
  localparam int FRAME_MAX           = (1 << FRAME_W) - 1;
  localparam int LONG_STALL          = 400;
  localparam int WATCHDOG_LIMIT      = 5000;
  localparam int SETTLE_CYCLES       = 100;
  localparam int EPISODES            = 10;
  localparam int QUERIES_PER_EPISODE = 34;
  localparam logic [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam logic [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

  logic               clk          = 1'b0;
  logic               rst          = 1'b1;
  logic               cfg_valid    = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data     = '0;
  logic               item_valid   = 1'b0;
  logic               item_ready;
  item_t              item         = '0;
  logic               result_valid;
  logic               result_ready = 1'b0;
  result_t            result;
  int                 error_count;
  int                 outstanding;
  int                 send_idle_pct = 26;
  int                 recv_idle_pct = 60;
  logic               stall_request = 1'b0;
  logic               stall_taken   = 1'b0;
  int                 stall_cycles  = 0;
  int                 quiet_cycles  = 0;
  logic [FRAME_W-1:0] stim_frames [KEY_SLOTS];

  int episode_counts [EPISODES] = '{64, 127, 2, 8, 33, 1, 0, 16, 65, 5};
  bit episode_reload [EPISODES] = '{1, 1, 1, 1, 1, 1, 0, 1, 0, 1};

  always #5 clk = ~clk;

  keyframe_scale_lerp_unit #(
    .MAX_KEYS(KEY_SLOTS)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  keyframe_scale_lerp_unit_checker #(
    .MAX_KEYS(KEY_SLOTS)
  ) i_checker (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result),
    .errors      (error_count),
    .outstanding (outstanding)
  );

  // Receiver: random idling, plus one long hold-off so the unit backs up.
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else if (stall_request && !stall_taken) begin
      stall_taken  <= 1'b1;
      stall_cycles <= LONG_STALL;
      result_ready <= 1'b0;
    end else if (stall_cycles != 0) begin
      stall_cycles <= stall_cycles - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("keyframe_scale_lerp_unit_test: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [VAL_W-1:0] random_value();
    case ($urandom_range(24))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  function automatic item_t random_item();
    item_t it;
    it.mode        = $urandom_range(1);
    it.key_slot    = $urandom();
    it.key_frame   = $urandom();
    it.key_x       = random_value();
    it.key_y       = random_value();
    it.key_z       = random_value();
    it.query_frame = $urandom();
    return it;
  endfunction

  // Aim mostly inside a segment, with some before the first and past the last key.
  function automatic logic [FRAME_W-1:0] pick_query_frame(input int n);
    int unsigned lo, hi, seg;
    int          pick;
    pick = $urandom_range(99);
    if (n >= 2 && pick < 70) begin
      seg = $urandom_range(n - 2);
      lo  = stim_frames[seg];
      hi  = stim_frames[seg + 1];
      if (hi <= lo)
        return lo;
      case ($urandom_range(4))
        0:       return lo;
        1:       return hi - 1;
        default: return $urandom_range(hi - 1, lo);
      endcase
    end
    if (n >= 1 && pick < 82) begin
      lo = stim_frames[0];
      return (lo == 0) ? 0 : $urandom_range(lo - 1);
    end
    if (n >= 1 && pick < 94) begin
      lo = stim_frames[n - 1];
      return ($urandom_range(1) != 0) ? lo : $urandom_range(FRAME_MAX, lo);
    end
    return $urandom();
  endfunction

  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
    if (it.mode == MODE_LOAD)
      stim_frames[it.key_slot] = it.key_frame;
  endtask

  task automatic send_load(input int slot, input logic [FRAME_W-1:0] frame,
                           input logic [VAL_W-1:0] x, input logic [VAL_W-1:0] y,
                           input logic [VAL_W-1:0] z);
    item_t it;
    it           = random_item();
    it.mode      = MODE_LOAD;
    it.key_slot  = slot;
    it.key_frame = frame;
    it.key_x     = x;
    it.key_y     = y;
    it.key_z     = z;
    send_item(it);
  endtask

  task automatic send_query(input logic [FRAME_W-1:0] frame);
    item_t it;
    it             = random_item();
    it.mode        = MODE_QUERY;
    it.query_frame = frame;
    send_item(it);
  endtask

  task automatic wait_for_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Write key_count only once every result has drained.
  task automatic settle_and_set_count(input logic [COUNT_W-1:0] count);
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= count;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Fill slots 0..count-1 with rising frames; gaps of zero make duplicate keys.
  task automatic load_sorted_keys(input int count);
    int unsigned frame, max_gap, gap;
    int          pick;
    pick    = $urandom_range(99);
    frame   = (pick < 25) ? 0 : $urandom_range((pick < 60) ? 1000 : FRAME_MAX / 2);
    max_gap = (FRAME_MAX - frame) / count;
    for (int k = 0; k < count; k++) begin
      send_load(k, frame, random_value(), random_value(), random_value());
      pick = $urandom_range(99);
      if (pick < 5)
        gap = 0;
      else if (pick < 20)
        gap = 1;
      else if (pick < 60)
        gap = $urandom_range(64, 1);
      else
        gap = $urandom_range(max_gap, 1);
      frame += gap;
    end
  endtask

  initial begin
    int n;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table
    send_query('0);
    send_query(FRAME_MAX);
    send_load(0, 100, VAL_MIN, VAL_MAX, '0);
    send_load(1, 356, VAL_MAX, VAL_MIN, '1);
    send_load(2, FRAME_MAX, '0, 1, VAL_MAX);
    send_load(KEY_SLOTS - 1, '0, '1, '1, '1);
    // single key: never a segment
    settle_and_set_count(1);
    send_query(100);
    send_query(99);
    settle_and_set_count(2);
    send_query(355);
    send_query(356);
    settle_and_set_count(3);
    send_query(99);
    send_query(100);
    send_query(228);
    send_query(355);
    send_query(356);
    send_query(FRAME_MAX - 1);
    send_query(FRAME_MAX);
    send_query('0);

    for (int ep = 0; ep < EPISODES; ep++) begin
      if (ep == 4) begin
        send_idle_pct = 60;
        recv_idle_pct <= 26;
      end
      if (ep == 7) begin
        send_idle_pct = 0;
        recv_idle_pct <= 0;
      end
      n = (episode_counts[ep] > KEY_SLOTS) ? KEY_SLOTS : episode_counts[ep];
      if (episode_reload[ep] && n > 0)
        load_sorted_keys(n);
      settle_and_set_count(episode_counts[ep]);
      stall_request <= (ep == 1);
      for (int q = 0; q < QUERIES_PER_EPISODE; q++) begin
        if ($urandom_range(99) < 8)
          send_item(random_item());
        else
          send_query(pick_query_frame(n));
      end
    end

    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("keyframe_scale_lerp_unit_test: clean");
    else
      $display("keyframe_scale_lerp_unit_test: errors");
    $finish;
  end

endmodule

// ----- keyframe_scale_lerp_unit.f -----
+incdir+src
src/ksl_pkg.sv
src/ksl_ram.sv
src/keyframe_scale_lerp_unit.sv
verif/keyframe_scale_lerp_unit_checker.sv
verif/keyframe_scale_lerp_unit_test.sv
